[design/page_framebuffer_byte_blit_macros.svh]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: assertion macros
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_BYTE_BLIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_BYTE_BLIT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property check
`define PFBB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication
`define PFBB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define PFBB_ASSERT(label, prop, msg)
`define PFBB_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

[design/pfbb_pkg.sv]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: package
// Geometry constants, opcodes, controller states and shared structs.
// ----------------------------------------------------------------------------
package pfbb_pkg;

   localparam int DISPLAY_WIDTH  = 84;
   localparam int DISPLAY_HEIGHT = 48;
   localparam int PAGE_COUNT     = DISPLAY_HEIGHT / 8;
   localparam int STORE_DEPTH    = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int SPILL_LIMIT    = DISPLAY_HEIGHT - 8;

   typedef enum logic [1:0] {
      OP_DRAW       = 2'd0,
      OP_CLEAR_BYTE = 2'd1,
      OP_CLEAR_ALL  = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MERGE1,
      ST_MERGE2,
      ST_READ
   } state_type;

   // Decoded target of one item
   typedef struct packed {
      logic              hit;
      logic              spill;
      logic [2:0]        shift;
      logic [ADDR_W-1:0] addr1;
      logic [ADDR_W-1:0] addr2;
   } job_type;

   // Store port controls
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

endpackage

[design/pfbb_store.sv]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: frame store
// One write and one read port, registered read data.
// ----------------------------------------------------------------------------
module pfbb_store (
   input  logic                 clock,
   input  pfbb_pkg::mem_ctl_type mem_ctl,
   output logic [7:0]           rd_data
);
   import pfbb_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_ctl.wr_addr] <= mem_ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[mem_ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pfbb_decode.sv]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: target decode
// Page/column bounds, spill test and store addresses of an item.
// ----------------------------------------------------------------------------
module pfbb_decode (
   input  logic [7:0]        req_column,
   input  logic [7:0]        req_row,
   output pfbb_pkg::job_type job
);
   import pfbb_pkg::*;

   logic [4:0]        page;
   logic              col_ok;
   logic              page_ok;
   logic [ADDR_W-1:0] base;

   assign page    = req_row[7:3];
   assign col_ok  = {1'b0, req_column} < 9'(DISPLAY_WIDTH);
   assign page_ok = {1'b0, page} < 6'(PAGE_COUNT);
   assign base    = ADDR_W'(page) * ADDR_W'(DISPLAY_WIDTH);

   always_comb begin
      job.hit   = col_ok && page_ok;
      job.shift = req_row[2:0];
      // spill only for an unaligned row with a page below it
      job.spill = (req_row[2:0] != 3'd0)
               && ({1'b0, req_row} < 9'(SPILL_LIMIT))
               && (({1'b0, page} + 6'd1) < 6'(PAGE_COUNT));
      job.addr1 = base + ADDR_W'(req_column);
      job.addr2 = base + ADDR_W'(req_column) + ADDR_W'(DISPLAY_WIDTH);
   end

endmodule

[design/pfbb_ctrl.sv]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: controller
// Clear sweep, read-modify-write sequencing and the result register.
// ----------------------------------------------------------------------------
`include "page_framebuffer_byte_blit_macros.svh"

module pfbb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_pixels,
   input  pfbb_pkg::job_type     dec,
   output pfbb_pkg::mem_ctl_type mem_ctl,
   input  logic [7:0]            rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_read_data
);
   import pfbb_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_index_ff, clear_index_in;
   job_type           job_ff, job_in;
   logic [7:0]        pix_ff, pix_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   opcode_type        op;
   logic              accept;
   logic              slot_free;
   logic [7:0]        lo_mask;
   logic [7:0]        new1;
   logic [7:0]        new2;

   assign op        = opcode_type'(req_opcode);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   // a read waits until the result register can take its byte
   assign req_ready = (state_ff == ST_IDLE) && (slot_free || op != OP_READ);
   assign accept    = req_valid && req_ready;

   assign lo_mask = ~(8'hFF << job_ff.shift);
   assign new1    = (rd_data & lo_mask) | (pix_ff << job_ff.shift);
   assign new2    = (rd_data & ~lo_mask) | (pix_ff >> (4'd8 - {1'b0, job_ff.shift}));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_index_ff == ADDR_W'(STORE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_CLEAR_ALL: state_in = ST_CLEAR;
                  OP_READ:      state_in = ST_READ;
                  default:      state_in = dec.hit ? ST_MERGE1 : ST_IDLE;
               endcase
            end
         end
         ST_MERGE1: state_in = job_ff.spill ? ST_MERGE2 : ST_IDLE;
         ST_MERGE2: state_in = ST_IDLE;
         ST_READ:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // store controls and datapath
   always_comb begin
      mem_ctl        = '0;
      clear_index_in = clear_index_ff;
      job_in         = job_ff;
      pix_in         = pix_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = clear_index_ff;
            mem_ctl.wr_data = 8'h00;
            clear_index_in  = (clear_index_ff == ADDR_W'(STORE_DEPTH - 1))
                              ? '0 : clear_index_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               job_in          = dec;
               pix_in          = (op == OP_DRAW) ? req_pixels : 8'h00;
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = dec.addr1;
            end
         end
         ST_MERGE1: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = job_ff.addr1;
            mem_ctl.wr_data = new1;
            mem_ctl.rd_en   = job_ff.spill;
            mem_ctl.rd_addr = job_ff.addr2;
         end
         ST_MERGE2: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = job_ff.addr2;
            mem_ctl.wr_data = new2;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = job_ff.hit ? rd_data : 8'h00;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_index_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_index_ff <= clear_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      pix_ff      <= pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   `PFBB_ASSERT_IMPL(a_no_rw_clash, mem_ctl.wr_en && mem_ctl.rd_en, mem_ctl.wr_addr != mem_ctl.rd_addr, "read and write hit the same entry")
   `PFBB_ASSERT_IMPL(a_wr_in_range, mem_ctl.wr_en, mem_ctl.wr_addr <= ADDR_W'(STORE_DEPTH - 1), "write beyond the store")
   `PFBB_ASSERT(a_rsp_from_read, $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ), "result without a read")
   `PFBB_ASSERT(a_spill_after_merge, (state_ff == ST_MERGE2) |-> $past(state_ff == ST_MERGE1 && job_ff.spill), "spill write without primary merge")

endmodule

[design/page_framebuffer_byte_blit.sv]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: top level
// Page-organised monochrome framebuffer with byte draw, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per valid/ready handshake: opcode, column, row and
//  pixels. Draw and clear-byte merge a shifted byte into its page byte and,
//  for an unaligned row with a page below, the spill into that page. Items
//  outside the display are dropped. A read returns one byte on rsp_*.
//  A draw or clear-byte reads its page byte when accepted, writes it in
//  MERGE1 and, on a spill, the page below in MERGE2 (one store write each,
//  one read port on the store). A read passes the store read register and
//  the result register to rsp_*. Clear-all sweeps the store one entry a
//  cycle, all 504 entries; after reset the same pass runs, req_ready low.
//  The result register holds a finished read while rsp_ready is low; draws
//  are still taken then, a further read waits until the register frees.
// ----------------------------------------------------------------------------
module page_framebuffer_byte_blit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_column,
   input  logic [7:0] req_row,
   input  logic [7:0] req_pixels,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);
   import pfbb_pkg::*;

   job_type     dec;
   mem_ctl_type mem_ctl;
   logic [7:0]  rd_data;

   pfbb_decode u_decode (
      .req_column (req_column),
      .req_row    (req_row),
      .job        (dec)
   );

   pfbb_store u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_data (rd_data)
   );

   pfbb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_pixels    (req_pixels),
      .dec           (dec),
      .mem_ctl       (mem_ctl),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data)
   );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Page framebuffer byte blitter: testbench
// Drives draw, clear-byte, clear-all and read items through the request
// channel, keeps a shadow copy of the page store and checks every read byte
// on the response channel. A directed table comes first, then random bursts
// with gaps on the sender and a changing stall pattern on the receiver.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfbb_pkg::*;

   localparam int RANDOM_ITEMS   = 500;
   localparam int DIRECTED_COUNT = 26;
   localparam int TAIL_CYCLES    = 600;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      opcode_type op;
      logic [7:0] column;
      logic [7:0] row;
      logic [7:0] pixels;
      logic       has_want;
      logic [7:0] want;
   } blit_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_opcode;
   logic [7:0] req_column;
   logic [7:0] req_row;
   logic [7:0] req_pixels;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_read_data;

   logic [7:0] frame_shadow [0:STORE_DEPTH-1];
   logic [7:0] expected_bytes [$];
   int         error_count;
   bit         draining;
   logic [7:0] last_column;
   logic [7:0] last_row;

   // Typed expectations only where the answer is obvious; the rest use the shadow.
   blit_row_type directed_rows [0:DIRECTED_COUNT-1] = '{
      '{OP_READ,       8'd0,   8'd0,   8'h00, 1'b1, 8'h00},
      '{OP_READ,       8'd83,  8'd47,  8'h00, 1'b1, 8'h00},
      '{OP_READ,       8'd255, 8'd255, 8'hFF, 1'b1, 8'h00},
      '{OP_DRAW,       8'd0,   8'd0,   8'hFF, 1'b0, 8'h00},
      '{OP_READ,       8'd0,   8'd0,   8'h00, 1'b1, 8'hFF},
      '{OP_DRAW,       8'd83,  8'd47,  8'hFF, 1'b0, 8'h00},
      '{OP_READ,       8'd83,  8'd40,  8'h00, 1'b0, 8'h00},
      '{OP_DRAW,       8'd10,  8'd3,   8'hA5, 1'b0, 8'h00},
      '{OP_READ,       8'd10,  8'd0,   8'h00, 1'b0, 8'h00},
      '{OP_READ,       8'd10,  8'd15,  8'h00, 1'b0, 8'h00},
      '{OP_DRAW,       8'd84,  8'd0,   8'hFF, 1'b0, 8'h00},
      '{OP_READ,       8'd84,  8'd0,   8'h00, 1'b1, 8'h00},
      '{OP_DRAW,       8'd5,   8'd48,  8'hFF, 1'b0, 8'h00},
      '{OP_READ,       8'd5,   8'd48,  8'h00, 1'b1, 8'h00},
      '{OP_DRAW,       8'd20,  8'd39,  8'hFF, 1'b0, 8'h00},
      '{OP_READ,       8'd20,  8'd32,  8'h00, 1'b0, 8'h00},
      '{OP_READ,       8'd20,  8'd40,  8'h00, 1'b0, 8'h00},
      '{OP_DRAW,       8'd20,  8'd41,  8'h5A, 1'b0, 8'h00},
      '{OP_READ,       8'd20,  8'd40,  8'h00, 1'b0, 8'h00},
      '{OP_CLEAR_BYTE, 8'd10,  8'd3,   8'hFF, 1'b0, 8'h00},
      '{OP_READ,       8'd10,  8'd0,   8'h00, 1'b0, 8'h00},
      '{OP_READ,       8'd10,  8'd8,   8'h00, 1'b0, 8'h00},
      '{OP_CLEAR_ALL,  8'd77,  8'd99,  8'h33, 1'b0, 8'h00},
      '{OP_READ,       8'd0,   8'd0,   8'h00, 1'b1, 8'h00},
      '{OP_READ,       8'd20,  8'd32,  8'h00, 1'b1, 8'h00},
      '{OP_DRAW,       8'd255, 8'd255, 8'h00, 1'b0, 8'h00}
   };

   page_framebuffer_byte_blit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_pixels    (req_pixels),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shift the byte into its page and, for an unaligned row with room below,
   // carry the spill into the next page.
   function automatic void merge_into_shadow(input logic [7:0] column,
                                             input logic [7:0] row,
                                             input logic [7:0] pixels);
      int unsigned page;
      int unsigned idx;
      logic [2:0]  shift;
      logic [15:0] placed;
      logic [7:0]  keep;
      page   = row >> 3;
      shift  = row[2:0];
      if (column >= DISPLAY_WIDTH || page >= PAGE_COUNT) return;
      placed = {8'h00, pixels} << shift;
      idx    = page * DISPLAY_WIDTH + column;
      keep   = ~(8'hFF << shift);
      frame_shadow[idx] = (frame_shadow[idx] & keep) | placed[7:0];
      if (shift != 3'd0 && int'(row) < SPILL_LIMIT && page + 1 < PAGE_COUNT) begin
         idx  = (page + 1) * DISPLAY_WIDTH + column;
         keep = ~(8'hFF >> (4'd8 - shift));
         frame_shadow[idx] = (frame_shadow[idx] & keep) | placed[15:8];
      end
   endfunction

   function automatic logic [7:0] shadow_read_byte(input logic [7:0] column,
                                                   input logic [7:0] row);
      int unsigned page;
      page = row >> 3;
      if (column >= DISPLAY_WIDTH || page >= PAGE_COUNT) return 8'h00;
      return frame_shadow[page * DISPLAY_WIDTH + column];
   endfunction

   function automatic void apply_item(input opcode_type op, input logic [7:0] column,
                                      input logic [7:0] row, input logic [7:0] pixels,
                                      input logic has_want, input logic [7:0] want);
      case (op)
         OP_DRAW:       merge_into_shadow(column, row, pixels);
         OP_CLEAR_BYTE: merge_into_shadow(column, row, 8'h00);
         OP_CLEAR_ALL: begin
            foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
         end
         default: begin
            if (has_want) expected_bytes.push_back(want);
            else expected_bytes.push_back(shadow_read_byte(column, row));
         end
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input logic [7:0] want,
                                           input logic [7:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
   endfunction

   // Entered at a falling edge; returns at the falling edge after acceptance.
   task automatic push_item(input opcode_type op, input logic [7:0] column,
                            input logic [7:0] row, input logic [7:0] pixels,
                            input logic has_want, input logic [7:0] want);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_column <= column;
      req_row    <= row;
      req_pixels <= pixels;
      do @(posedge clock); while (req_ready !== 1'b1);
      apply_item(op, column, row, pixels, has_want, want);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      req_valid  <= 1'b0;
      req_opcode <= 2'($urandom_range(3));
      req_column <= 8'($urandom_range(255));
      req_row    <= 8'($urandom_range(255));
      req_pixels <= 8'($urandom_range(255));
      repeat (cycles) @(negedge clock);
   endtask

   task automatic push_random_item();
      int unsigned roll;
      opcode_type  op;
      logic [7:0]  column;
      logic [7:0]  row;
      roll = $urandom_range(99);
      if (roll < 40) op = OP_DRAW;
      else if (roll < 53) op = OP_CLEAR_BYTE;
      else if (roll < 55) op = OP_CLEAR_ALL;
      else op = OP_READ;

      roll = $urandom_range(99);
      if (roll < 45) column = 8'($urandom_range(7));
      else if (roll < 88) column = 8'($urandom_range(DISPLAY_WIDTH - 1));
      else column = 8'($urandom_range(255, DISPLAY_WIDTH));
      roll = $urandom_range(99);
      if (roll < 88) row = 8'($urandom_range(DISPLAY_HEIGHT - 1));
      else row = 8'($urandom_range(255, DISPLAY_HEIGHT));

      // Reads often go back to the last draw, its page or the page below.
      if (op == OP_READ && $urandom_range(1) == 1) begin
         column = last_column;
         row    = ($urandom_range(1) == 1) ? last_row + 8'd8 : last_row;
      end
      if (op == OP_DRAW || op == OP_CLEAR_BYTE) begin
         last_column = column;
         last_row    = row;
      end
      push_item(op, column, row, 8'($urandom_range(255)), 1'b0, 8'h00);
   endtask

   // Receiver: stall pattern switches now and then between modes.
   initial begin
      int unsigned tick;
      int unsigned mode;
      rsp_ready = 1'b0;
      tick = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (tick % 97 == 0) mode = $urandom_range(3);
         tick++;
         if (draining) rsp_ready <= 1'b1;
         else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(1));
               2:       rsp_ready <= (tick % 16) >= 5;
               default: rsp_ready <= (tick % 40) >= 30;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_bytes.size() == 0)
            report_mismatch("read byte with nothing pending", 8'h00, rsp_read_data);
         else begin
            logic [7:0] want;
            want = expected_bytes.pop_front();
            if (rsp_read_data !== want) report_mismatch("read_data", want, rsp_read_data);
         end
      end
   end

   initial begin
      int sent;
      int burst;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = 2'd0;
      req_column  = 8'd0;
      req_row     = 8'd0;
      req_pixels  = 8'd0;
      error_count = 0;
      draining    = 1'b0;
      last_column = 8'd0;
      last_row    = 8'd0;
      foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         push_item(directed_rows[i].op, directed_rows[i].column, directed_rows[i].row,
                   directed_rows[i].pixels, directed_rows[i].has_want,
                   directed_rows[i].want);
         if ($urandom_range(3) == 0) idle_for($urandom_range(1, 4));
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            push_random_item();
            sent++;
         end
         // About a third of bursts run straight into the next one.
         if ($urandom_range(2) != 0) idle_for($urandom_range(1, 10));
      end
      idle_for(1);

      draining = 1'b1;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch("read byte never returned", expected_bytes[0], 8'h00);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/pfbb_pkg.sv
design/pfbb_store.sv
design/pfbb_decode.sv
design/pfbb_ctrl.sv
design/page_framebuffer_byte_blit.sv
test/testbench.sv
